// ===== rtl/pss_pkg.sv =====
`default_nettype none

package pss_pkg;

  // Special code points
  localparam logic [20:0] CP_TAB   = 21'h00_0009;
  localparam logic [20:0] CP_LF    = 21'h00_000A;
  localparam logic [20:0] CP_CR    = 21'h00_000D;
  localparam logic [20:0] CP_SPACE = 21'h00_0020;
  localparam logic [20:0] CP_DEL   = 21'h00_007F;
  localparam logic [20:0] CP_C1_LO = 21'h00_0080;
  localparam logic [20:0] CP_NEL   = 21'h00_0085;
  localparam logic [20:0] CP_C1_HI = 21'h00_009F;
  localparam logic [20:0] CP_LSEP  = 21'h00_2028;
  localparam logic [20:0] CP_PSEP  = 21'h00_2029;
  localparam logic [20:0] CP_SUR_LO = 21'h00_D800;
  localparam logic [20:0] CP_SUR_HI = 21'h00_DFFF;
  localparam logic [20:0] CP_MAX    = 21'h10_FFFF;
  localparam logic [20:0] CP_REPL   = 21'h00_FFFD;

  // Bytes on the wire
  localparam logic [7:0] NEWLINE_BYTE = 8'h0D;
  localparam logic [7:0] SPACE_BYTE   = 8'h20;
  localparam logic [7:0] TILDE_BYTE   = 8'h7E;
  localparam logic [7:0] LBRACK_BYTE  = 8'h5B;

  localparam logic [0:5][7:0] START_MARKER = {8'h1B, 8'h5B, 8'h32, 8'h30, 8'h30, 8'h7E};
  localparam logic [0:5][7:0] END_MARKER   = {8'h1B, 8'h5B, 8'h32, 8'h30, 8'h31, 8'h7E};
  localparam logic [0:3][7:0] GUARD_RUN    = {8'h5B, 8'h32, 8'h30, 8'h31};

  localparam int unsigned MARKER_LEN = 6;
  localparam logic [2:0]  GUARD_FULL = 3'd4;

  // Risk codes
  localparam logic [1:0] RISK_NONE      = 2'd0;
  localparam logic [1:0] RISK_MULTILINE = 2'd1;
  localparam logic [1:0] RISK_TRAILING  = 2'd2;

  // Work for the back end, one per item that produces output
  typedef struct packed {
    logic            start;   // send start marker
    logic            nl_pre;  // held CR released before the character
    logic [3:0][7:0] chr;     // UTF-8 bytes (or newline byte)
    logic [2:0]      nchar;   // 0..4
    logic            nl_post; // held CR released at end of paste
    logic            endm;    // send end marker
    logic            br;      // bracket mode seen by this item
    logic            last;
    logic [1:0]      risk;
    logic            san;
  } desc_t;

endpackage

`default_nettype wire

// ===== rtl/pss_front.sv =====
`default_nettype none

module pss_front
  import pss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_bracket_mode_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [20:0] code_point_i,
  input  wire logic        has_char_i,
  input  wire logic        last_i,
  input  wire logic        q_full_i,
  output logic             q_push_o,
  output desc_t            q_data_o
);

  logic br_q;
  logic prev_cr_q, prev_cr_d;
  logic nl_pend_q, nl_pend_d;
  logic multi_q, multi_d;
  logic san_q, san_d;
  logic prefix_q;

  logic        accept;
  logic        done_lf, is_hold, is_nl, is_drop, is_char;
  logic [20:0] cpf;
  desc_t       d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign accept      = in_valid_i && in_ready_o;

  // Classify the item and build its work descriptor
  always_comb begin
    d         = '0;
    d.br      = br_q;
    d.last    = last_i;
    d.start   = br_q && !prefix_q;
    d.nl_pre  = has_char_i && prev_cr_q;
    done_lf   = d.nl_pre && (code_point_i == CP_LF);

    is_hold = has_char_i && !done_lf && (code_point_i == CP_CR);
    is_nl   = has_char_i && !done_lf &&
              ((code_point_i == CP_LF) || (code_point_i == CP_NEL) ||
               (code_point_i == CP_LSEP) || (code_point_i == CP_PSEP));
    is_drop = has_char_i && !done_lf && !is_hold && !is_nl &&
              (code_point_i != CP_TAB) &&
              ((code_point_i < CP_SPACE) || (code_point_i == CP_DEL) ||
               ((code_point_i >= CP_C1_LO) && (code_point_i <= CP_C1_HI)));
    is_char = has_char_i && !done_lf && !is_hold && !is_nl && !is_drop;

    // UTF-8 encode, invalid scalars become the replacement character
    cpf = code_point_i;
    if (((cpf >= CP_SUR_LO) && (cpf <= CP_SUR_HI)) || (cpf > CP_MAX)) begin
      cpf = CP_REPL;
    end
    if (is_nl) begin
      d.chr[0] = NEWLINE_BYTE;
      d.nchar  = 3'd1;
    end else if (is_char) begin
      if (cpf < 21'h80) begin
        d.chr[0] = {1'b0, cpf[6:0]};
        d.nchar  = 3'd1;
      end else if (cpf < 21'h800) begin
        d.chr[0] = {3'b110, cpf[10:6]};
        d.chr[1] = {2'b10, cpf[5:0]};
        d.nchar  = 3'd2;
      end else if (cpf < 21'h10000) begin
        d.chr[0] = {4'b1110, cpf[15:12]};
        d.chr[1] = {2'b10, cpf[11:6]};
        d.chr[2] = {2'b10, cpf[5:0]};
        d.nchar  = 3'd3;
      end else begin
        d.chr[0] = {5'b11110, cpf[20:18]};
        d.chr[1] = {2'b10, cpf[17:12]};
        d.chr[2] = {2'b10, cpf[11:6]};
        d.chr[3] = {2'b10, cpf[5:0]};
        d.nchar  = 3'd4;
      end
    end

    // Held CR tracking
    prev_cr_d = prev_cr_q;
    if (has_char_i) begin
      prev_cr_d = is_hold;
    end
    d.nl_post = last_i && prev_cr_d;
    d.endm    = last_i && br_q;

    // Kept-character history, in emit order
    nl_pend_d = nl_pend_q;
    multi_d   = multi_q;
    if (d.nl_pre) begin
      multi_d   = multi_d | nl_pend_d;
      nl_pend_d = 1'b1;
    end
    if (is_nl || is_char) begin
      multi_d   = multi_d | nl_pend_d;
      nl_pend_d = is_nl;
    end
    if (d.nl_post) begin
      multi_d   = multi_d | nl_pend_d;
      nl_pend_d = 1'b1;
    end
    san_d = san_q | done_lf | is_drop;

    d.san  = san_d;
    d.risk = multi_d ? RISK_MULTILINE : (nl_pend_d ? RISK_TRAILING : RISK_NONE);
  end

  assign q_data_o = d;
  assign q_push_o = accept && (d.start || d.nl_pre || (d.nchar != 3'd0) ||
                               d.nl_post || d.endm || last_i);

  // Bracket mode and paste state; paste state is cleared after the last item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q      <= 1'b0;
      prev_cr_q <= 1'b0;
      nl_pend_q <= 1'b0;
      multi_q   <= 1'b0;
      san_q     <= 1'b0;
      prefix_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        br_q <= cfg_bracket_mode_i;
      end
      if (accept) begin
        if (last_i) begin
          prev_cr_q <= 1'b0;
          nl_pend_q <= 1'b0;
          multi_q   <= 1'b0;
          san_q     <= 1'b0;
          prefix_q  <= 1'b0;
        end else begin
          prev_cr_q <= prev_cr_d;
          nl_pend_q <= nl_pend_d;
          multi_q   <= multi_d;
          san_q     <= san_d;
          prefix_q  <= prefix_q | d.start;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pss_queue.sv =====
`default_nettype none

module pss_queue
  import pss_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire desc_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output desc_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pss_back.sv =====
`default_nettype none

module pss_back
  import pss_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       q_valid_i,
  input  wire desc_t      q_data_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            end_of_run_o,
  output logic            paste_done_o,
  output logic [1:0]      risk_o,
  output logic            sanitised_o
);

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_NL_PRE = 3'd1,
    PH_CHAR   = 3'd2,
    PH_NL_POST = 3'd3,
    PH_END    = 3'd4,
    PH_STATUS = 3'd5,
    PH_NONE   = 3'd6
  } phase_e;

  // First non-empty segment after the given one
  function automatic phase_e next_phase(desc_t dd, phase_e ph);
    phase_e r;
    r = PH_NONE;
    if ((ph < PH_NL_PRE) && dd.nl_pre) begin
      r = PH_NL_PRE;
    end else if ((ph < PH_CHAR) && (dd.nchar != 3'd0)) begin
      r = PH_CHAR;
    end else if ((ph < PH_NL_POST) && dd.nl_post) begin
      r = PH_NL_POST;
    end else if ((ph < PH_END) && dd.endm) begin
      r = PH_END;
    end
    return r;
  endfunction

  phase_e     phase_q, ph, first_ph, nxt;
  logic [2:0] idx_q, idx;
  logic       started_q, tilde_q;
  logic [2:0] prog_q;

  logic       ov_q;
  logic [7:0] byte_q;
  logic       bvalid_q, eor_q, done_q, san_q;
  logic [1:0] risk_q;

  logic       adv, fire, payload, split, seg_last, final_b;
  logic [7:0] raw_b, emit_b;
  logic [2:0] prog_n;

  assign adv  = !ov_q || out_ready_i;
  assign fire = adv && q_valid_i;

  // Where the head descriptor stands
  always_comb begin
    nxt      = next_phase(q_data_i, PH_START);
    first_ph = q_data_i.start ? PH_START : ((nxt == PH_NONE) ? PH_STATUS : nxt);
    ph       = started_q ? phase_q : first_ph;
    idx      = started_q ? idx_q : 3'd0;
  end

  // Byte of the current segment
  always_comb begin
    raw_b    = '0;
    seg_last = 1'b1;
    payload  = 1'b0;
    unique case (ph)
      PH_START: begin
        raw_b    = START_MARKER[idx];
        seg_last = (idx == 3'(MARKER_LEN - 1));
      end
      PH_NL_PRE, PH_NL_POST: begin
        raw_b   = NEWLINE_BYTE;
        payload = 1'b1;
      end
      PH_CHAR: begin
        raw_b    = q_data_i.chr[idx[1:0]];
        seg_last = (idx == (q_data_i.nchar - 3'd1));
        payload  = 1'b1;
      end
      PH_END: begin
        raw_b    = END_MARKER[idx];
        seg_last = (idx == 3'(MARKER_LEN - 1));
      end
      default: begin
        raw_b = '0;
      end
    endcase
  end

  // End-marker escape on the payload and the guard-run tracker
  always_comb begin
    split = payload && q_data_i.br && (prog_q == GUARD_FULL) &&
            (raw_b == TILDE_BYTE) && !tilde_q;
    emit_b  = split ? SPACE_BYTE : raw_b;
    final_b = !split && seg_last && (next_phase(q_data_i, ph) == PH_NONE);
    prog_n  = prog_q;
    if (payload && q_data_i.br && !split) begin
      if ((prog_q == GUARD_FULL) && (raw_b == TILDE_BYTE)) begin
        prog_n = 3'd0;
      end else if ((prog_q < GUARD_FULL) && (raw_b == GUARD_RUN[prog_q[1:0]])) begin
        prog_n = prog_q + 3'd1;
      end else begin
        prog_n = (raw_b == LBRACK_BYTE) ? 3'd1 : 3'd0;
      end
    end
    if (final_b && q_data_i.last) begin
      prog_n = 3'd0;
    end
  end

  assign q_pop_o = fire && final_b;

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      idx_q     <= '0;
      started_q <= 1'b0;
      tilde_q   <= 1'b0;
      prog_q    <= '0;
    end else if (fire) begin
      prog_q <= prog_n;
      if (split) begin
        tilde_q   <= 1'b1;
        started_q <= 1'b1;
        phase_q   <= ph;
        idx_q     <= idx;
      end else begin
        tilde_q <= 1'b0;
        if (final_b) begin
          started_q <= 1'b0;
        end else begin
          started_q <= 1'b1;
          if (seg_last) begin
            phase_q <= next_phase(q_data_i, ph);
            idx_q   <= '0;
          end else begin
            phase_q <= ph;
            idx_q   <= idx + 3'd1;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv) begin
      ov_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q   <= emit_b;
      bvalid_q <= (ph != PH_STATUS);
      eor_q    <= final_b;
      done_q   <= final_b && q_data_i.last;
      risk_q   <= (final_b && q_data_i.last) ? q_data_i.risk : RISK_NONE;
      san_q    <= final_b && q_data_i.last && q_data_i.san;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_byte_o   = byte_q;
  assign byte_valid_o = bvalid_q;
  assign end_of_run_o = eor_q;
  assign paste_done_o = done_q;
  assign risk_o       = risk_q;
  assign sanitised_o  = san_q;

endmodule

`default_nettype wire

// ===== rtl/paste_stream_sanitizer_unit.sv =====
// An item's first byte goes through the descriptor queue, then the output register.
// Throughput: one output byte per cycle from the back-end sequencer while out_ready_i
//   is high and a descriptor is waiting; an item yields 0 to 17 bytes.
// The front end accepts an item per cycle while the descriptor queue has room.
// Reset (rst_ni, async, active low) clears paste state, queue and output valid flag;
//   bracket mode resets to 0.
`default_nettype none

module paste_stream_sanitizer_unit
  import pss_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_bracket_mode_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [20:0] code_point_i,
  input  wire logic        has_char_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             end_of_run_o,
  output logic             paste_done_o,
  output logic [1:0]       risk_o,
  output logic             sanitised_o
);

  logic  q_full, q_push, q_valid, q_pop;
  desc_t q_wdata, q_rdata;

  pss_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_bracket_mode_i (cfg_bracket_mode_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .code_point_i       (code_point_i),
    .has_char_i         (has_char_i),
    .last_i             (last_i),
    .q_full_i           (q_full),
    .q_push_o           (q_push),
    .q_data_o           (q_wdata)
  );

  pss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  pss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .end_of_run_o (end_of_run_o),
    .paste_done_o (paste_done_o),
    .risk_o       (risk_o),
    .sanitised_o  (sanitised_o)
  );

endmodule

`default_nettype wire

// ===== rtl/pss_checker.sv =====
`default_nettype none

module pss_checker
  import pss_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       byte_valid_o,
  input wire logic       end_of_run_o,
  input wire logic       paste_done_o,
  input wire logic [1:0] risk_o,
  input wire logic       sanitised_o
);

  // A stalled transaction holds its byte
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output transaction changed while stalled");

  // End of paste closes the item's run and carries a legal risk code
  a_done_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && paste_done_o |-> end_of_run_o && (risk_o <= RISK_TRAILING))
    else $error("paste_done without end_of_run or bad risk");

  // Status-only transaction only ends a paste
  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> paste_done_o && (out_byte_o == 8'h00))
    else $error("status-only transaction not at end of paste");

  // Summary fields only on the final transaction
  a_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((risk_o != RISK_NONE) || sanitised_o) |-> paste_done_o)
    else $error("risk or sanitised outside paste_done");

endmodule

bind paste_stream_sanitizer_unit pss_checker u_pss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .byte_valid_o (byte_valid_o),
  .end_of_run_o (end_of_run_o),
  .paste_done_o (paste_done_o),
  .risk_o       (risk_o),
  .sanitised_o  (sanitised_o)
);

`default_nettype wire

// ===== sim/paste_stream_sanitizer_unit_tb.sv =====
`default_nettype none

module paste_stream_sanitizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  // One output transaction as seen on the result port
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_run;
    logic       paste_done;
    logic [1:0] risk;
    logic       sanitised;
  } paste_byte_t;

  // One input transaction
  typedef struct packed {
    logic [20:0] code_point;
    logic        has_char;
    logic        last;
  } paste_item_t;

  // Directed stimulus row: bracket mode to use, the item, and an optional typed-in result
  typedef struct packed {
    logic        mode;
    logic [20:0] code_point;
    logic        has_char;
    logic        last;
    logic        typed;
    paste_byte_t want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_bracket_mode_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [20:0] code_point_i = '0;
  logic        has_char_i = 1'b0;
  logic        last_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        byte_valid_o;
  logic        end_of_run_o;
  logic        paste_done_o;
  logic [1:0]  risk_o;
  logic        sanitised_o;

  paste_stream_sanitizer_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_bracket_mode_i(cfg_bracket_mode_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .code_point_i      (code_point_i),
    .has_char_i        (has_char_i),
    .last_i            (last_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .byte_valid_o      (byte_valid_o),
    .end_of_run_o      (end_of_run_o),
    .paste_done_o      (paste_done_o),
    .risk_o            (risk_o),
    .sanitised_o       (sanitised_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Sanitizer shadow state
  logic       mode_q;
  logic       cr_held;
  logic       nl_pending;
  logic       multi_seen;
  logic       san_seen;
  logic [2:0] guard_cnt;
  logic       start_sent;

  logic [7:0]  run_bytes[$];
  paste_byte_t item_bytes[$];
  paste_byte_t awaited_bytes[$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic void clear_paste();
    cr_held    = 1'b0;
    nl_pending = 1'b0;
    multi_seen = 1'b0;
    san_seen   = 1'b0;
    guard_cnt  = '0;
    start_sent = 1'b0;
  endfunction

  // Payload byte with the end-marker escape tracking in bracket mode
  function automatic void put_payload(logic [7:0] b, logic br);
    if (br) begin
      if (guard_cnt == GUARD_FULL && b == TILDE_BYTE) begin
        run_bytes.push_back(SPACE_BYTE);
        run_bytes.push_back(TILDE_BYTE);
        guard_cnt = '0;
        return;
      end
      if (guard_cnt < GUARD_FULL && b == GUARD_RUN[guard_cnt[1:0]])
        guard_cnt = guard_cnt + 3'd1;
      else
        guard_cnt = (b == LBRACK_BYTE) ? 3'd1 : 3'd0;
    end
    run_bytes.push_back(b);
  endfunction

  function automatic void note_kept(logic is_nl);
    if (nl_pending) multi_seen = 1'b1;
    nl_pending = is_nl;
  endfunction

  function automatic void put_newline(logic br);
    note_kept(1'b1);
    put_payload(NEWLINE_BYTE, br);
  endfunction

  // UTF-8 encode a kept character; surrogates and out-of-range map to U+FFFD
  function automatic void put_char(logic [20:0] cp, logic br);
    logic [20:0] c;
    c = cp;
    if ((c >= CP_SUR_LO && c <= CP_SUR_HI) || c > CP_MAX) c = CP_REPL;
    note_kept(1'b0);
    if (c < 21'h80) begin
      put_payload(c[7:0], br);
    end else if (c < 21'h800) begin
      put_payload({3'b110, c[10:6]}, br);
      put_payload({2'b10, c[5:0]}, br);
    end else if (c < 21'h10000) begin
      put_payload({4'b1110, c[15:12]}, br);
      put_payload({2'b10, c[11:6]}, br);
      put_payload({2'b10, c[5:0]}, br);
    end else begin
      put_payload({5'b11110, c[20:18]}, br);
      put_payload({2'b10, c[17:12]}, br);
      put_payload({2'b10, c[11:6]}, br);
      put_payload({2'b10, c[5:0]}, br);
    end
  endfunction

  // Work out every result one accepted item causes, into item_bytes
  function automatic void sanitize_item(logic [20:0] cp, logic has, logic lst);
    logic        br;
    logic        collapsed;
    logic [1:0]  rk;
    logic        fin;
    paste_byte_t r;
    br = mode_q;
    rk = RISK_NONE;
    run_bytes.delete();
    item_bytes.delete();
    if (br && !start_sent) begin
      for (int i = 0; i < MARKER_LEN; i++) run_bytes.push_back(START_MARKER[i]);
      start_sent = 1'b1;
    end
    if (has) begin
      collapsed = 1'b0;
      // held CR goes out first; LF right after it is absorbed
      if (cr_held) begin
        cr_held = 1'b0;
        if (cp == CP_LF) begin
          san_seen  = 1'b1;
          collapsed = 1'b1;
        end
        put_newline(br);
      end
      if (!collapsed) begin
        if (cp == CP_CR)
          cr_held = 1'b1;
        else if (cp == CP_LF || cp == CP_NEL || cp == CP_LSEP || cp == CP_PSEP)
          put_newline(br);
        else if (cp == CP_TAB)
          put_char(cp, br);
        else if (cp < CP_SPACE || cp == CP_DEL || (cp >= CP_C1_LO && cp <= CP_C1_HI))
          san_seen = 1'b1;
        else
          put_char(cp, br);
      end
    end
    if (lst) begin
      if (cr_held) begin
        cr_held = 1'b0;
        put_newline(br);
      end
      if (br)
        for (int i = 0; i < MARKER_LEN; i++) run_bytes.push_back(END_MARKER[i]);
      if (multi_seen) rk = RISK_MULTILINE;
      else if (nl_pending) rk = RISK_TRAILING;
    end
    if (run_bytes.size() == 0) begin
      if (lst) begin
        r = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_run: 1'b1, paste_done: 1'b1,
              risk: rk, sanitised: san_seen};
        item_bytes.push_back(r);
      end
    end else begin
      foreach (run_bytes[k]) begin
        fin = (k == run_bytes.size() - 1);
        r.out_byte   = run_bytes[k];
        r.byte_valid = 1'b1;
        r.end_of_run = fin;
        r.paste_done = fin && lst;
        r.risk       = (fin && lst) ? rk : RISK_NONE;
        r.sanitised  = fin && lst && san_seen;
        item_bytes.push_back(r);
      end
    end
    if (lst) clear_paste();
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Result side: random back-pressure and comparison against the oldest expectation
  always @(posedge clk_i) begin
    paste_byte_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_bytes.size() == 0) begin
        $error("result byte 0x%0h arrived with nothing outstanding", out_byte_o);
        mismatch_count++;
      end else begin
        w = awaited_bytes.pop_front();
        check_field("out_byte", w.out_byte, out_byte_o);
        check_field("byte_valid", w.byte_valid, byte_valid_o);
        check_field("end_of_run", w.end_of_run, end_of_run_o);
        check_field("paste_done", w.paste_done, paste_done_o);
        check_field("risk", w.risk, risk_o);
        check_field("sanitised", w.sanitised, sanitised_o);
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one item; valid stays high from the previous transaction unless we idle
  task automatic send_item(logic [20:0] cp, logic has, logic lst, logic typed,
                           paste_byte_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    code_point_i <= cp;
    has_char_i   <= has;
    last_i       <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    sanitize_item(cp, has, lst);
    if (typed) awaited_bytes.push_back(want);
    else foreach (item_bytes[k]) awaited_bytes.push_back(item_bytes[k]);
  endtask

  // Stop sending and let the block empty out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_bracket_mode(logic m);
    wait_drained();
    cfg_valid_i        <= 1'b1;
    cfg_bracket_mode_i <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    mode_q = m;
  endtask

  // Random code point, weighted toward the interesting classes
  function automatic paste_item_t pick_item();
    paste_item_t it;
    int unsigned sel;
    logic [7:0]  guard_chars[5];
    guard_chars = '{8'h5B, 8'h32, 8'h30, 8'h31, TILDE_BYTE};
    sel = $urandom_range(99);
    it.has_char = 1'b1;
    it.last     = 1'b0;
    if (sel < 25)      it.code_point = 21'($urandom_range(32, 126));
    else if (sel < 35) it.code_point = {13'd0, guard_chars[$urandom_range(4)]};
    else if (sel < 43) it.code_point = CP_CR;
    else if (sel < 50) it.code_point = CP_LF;
    else if (sel < 55) begin
      case ($urandom_range(2))
        0:       it.code_point = CP_NEL;
        1:       it.code_point = CP_LSEP;
        default: it.code_point = CP_PSEP;
      endcase
    end else if (sel < 65) begin
      case ($urandom_range(2))
        0:       it.code_point = 21'($urandom_range(0, 31));
        1:       it.code_point = CP_DEL;
        default: it.code_point = 21'($urandom_range(CP_C1_LO, CP_C1_HI));
      endcase
    end else if (sel < 82) it.code_point = 21'($urandom_range(21'hA0, CP_MAX));
    else if (sel < 87) it.code_point = 21'($urandom_range(CP_SUR_LO, CP_SUR_HI));
    else if (sel < 94) it.code_point = 21'($urandom_range(0, 21'h1F_FFFF));
    else begin
      it.has_char   = 1'b0;
      it.code_point = 21'($urandom_range(0, 21'h1F_FFFF));
    end
    return it;
  endfunction

  // Random paste of 1..8 random items, sometimes led by the end-marker text
  task automatic send_random_paste(output int unsigned count);
    paste_item_t items[$];
    paste_item_t it;
    int unsigned len;
    logic [7:0]  guard_text[5];
    guard_text = '{8'h5B, 8'h32, 8'h30, 8'h31, TILDE_BYTE};
    len = $urandom_range(1, 8);
    if ($urandom_range(4) == 0) begin
      foreach (guard_text[k]) begin
        it = '{code_point: {13'd0, guard_text[k]}, has_char: 1'b1, last: 1'b0};
        items.push_back(it);
      end
    end
    repeat (len) items.push_back(pick_item());
    items[items.size() - 1].last = 1'b1;
    foreach (items[k])
      send_item(items[k].code_point, items[k].has_char, items[k].last, 1'b0, '0);
    count = items.size();
  endtask

  // Directed script: empty paste, extremes, each line-ending and drop class, escape, mode change
  script_row_t script[26] = '{
    '{1'b0, 21'h0, 1'b0, 1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b1, RISK_NONE, 1'b0}},
    '{1'b0, 21'h41, 1'b1, 1'b1, 1'b1,
      '{8'h41, 1'b1, 1'b1, 1'b1, RISK_NONE, 1'b0}},
    '{1'b0, 21'h01, 1'b1, 1'b1, 1'b1,
      '{8'h00, 1'b0, 1'b1, 1'b1, RISK_NONE, 1'b1}},
    '{1'b0, CP_CR, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_LF, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_CR, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_DEL, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_NEL, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_LSEP, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_PSEP, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_TAB, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_C1_LO, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 21'h7FF, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 21'hFFFF, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_MAX, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_SUR_LO, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 21'h1F_FFFF, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, CP_CR, 1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 21'h5B, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 21'h32, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 21'h30, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 21'h31, 1'b1, 1'b0, 1'b0, '0},
    '{1'b1, 21'h7E, 1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 21'h71, 1'b1, 1'b0, 1'b0, '0},
    '{1'b0, 21'h7E, 1'b1, 1'b1, 1'b0, '0},
    '{1'b1, 21'h0, 1'b0, 1'b1, 1'b0, '0}
  };

  // Main sequence
  initial begin
    int unsigned sent;
    int unsigned cnt;
    int unsigned pastes;
    mode_q = 1'b0;
    clear_paste();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].mode != mode_q) set_bracket_mode(script[i].mode);
      send_item(script[i].code_point, script[i].has_char, script[i].last,
                script[i].typed, script[i].want);
    end

    // Random phases with different idle patterns and bracket mode settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      set_bracket_mode(ph % 2 == 0);
      sent   = 0;
      pastes = 0;
      while (sent < 24) begin
        send_random_paste(cnt);
        sent += cnt;
        pastes++;
        // hold off once until the output has fully drained
        if (ph == 0 && pastes == 2) wait_drained();
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ===== paste_stream_sanitizer_unit.f =====
rtl/pss_pkg.sv
rtl/pss_front.sv
rtl/pss_queue.sv
rtl/pss_back.sv
rtl/paste_stream_sanitizer_unit.sv
rtl/pss_checker.sv
sim/paste_stream_sanitizer_unit_tb.sv
